>>> rtl/core/rchop_pkg.sv
// Shared types, constants and the hop channel table for the hopping link and frame builder.
// Used by rchop_ctrl, rchop_dp and the top level rc_hop_link_and_frame_builder.
package rchop_pkg;

	localparam int CHANNELS = 7;
	localparam int IN_CHANS = 7;
	// Number of channels carried in one output frame.
	localparam int NCH = (CHANNELS < IN_CHANS) ? CHANNELS : IN_CHANS;
	localparam int CH_W = 3;
	localparam int HOP_LEN = 16;
	localparam int HOP_W = $clog2(HOP_LEN);
	localparam int ADDR_W = 4;

	localparam logic [7:0] FRAME_SYNC0 = 8'h00;
	localparam logic [7:0] FRAME_SYNC1 = 8'hB2;
	localparam logic [15:0] RAW_OFFSET = 16'd1000;
	localparam logic [26:0] ROUND_ADD = 27'd500;
	localparam logic [10:0] SCALE_WIDE = 11'd2047;
	localparam logic [10:0] SCALE_NARROW = 11'd1023;
	// ceil(2^37 / 1000): exact quotient by 1000 for any 27-bit dividend.
	localparam logic [27:0] RECIP_1000 = 28'd137438954;
	localparam int RECIP_SHIFT = 37;
	localparam logic [15:0] LOST_LIMIT = 16'd120;
	localparam logic [15:0] LOST_MAX = 16'hFFFF;
	localparam logic [4:0] LIM_LONG = 5'd16;
	localparam logic [4:0] LIM_SHORT = 5'd15;
	localparam logic [4:0] SIL_MAX = 5'd31;
	localparam logic [3:0] OFFS_MAX = 4'd9;
	localparam logic [7:0] TIMER_MAX = 8'hFF;

	localparam logic [31:0] TX_ID_RST = 32'd0;
	localparam logic WIDE_RST = 1'b1;
	localparam logic [7:0] PERIOD_RST = 8'd110;
	localparam logic [7:0] FPP_RST = 8'd3;

	localparam logic KIND_CHAN = 1'b0;
	localparam logic KIND_BYTE = 1'b1;

	typedef enum logic [1:0] {
		REG_TX_ID  = 2'd0,
		REG_WIDE   = 2'd1,
		REG_PERIOD = 2'd2,
		REG_FPP    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HOP,
		S_HDR0,
		S_HDR1,
		S_CHHI,
		S_CHLO
	} ctrl_state_t;

	typedef enum logic [2:0] {
		SEL_HOP,
		SEL_SYNC0,
		SEL_SYNC1,
		SEL_HI,
		SEL_LO
	} byte_sel_t;

	typedef struct packed {
		logic            accept;
		logic            emit;
		byte_sel_t       sel;
		logic            last;
		logic [CH_W-1:0] ch;
	} dp_cmd_t;

	typedef struct packed {
		logic hop_now;
		logic frame_now;
		logic out_free;
		logic ch_ready;
	} dp_status_t;

	// Hop channel table, indexed by {row, column}.
	localparam logic [0:255][7:0] HOP_ROM = {
		8'h0a, 8'h5a, 8'h14, 8'h64, 8'h1e, 8'h6e, 8'h28, 8'h78,
		8'h32, 8'h82, 8'h3c, 8'h8c, 8'h46, 8'h96, 8'h50, 8'ha0,
		8'ha0, 8'h50, 8'h96, 8'h46, 8'h8c, 8'h3c, 8'h82, 8'h32,
		8'h78, 8'h28, 8'h6e, 8'h1e, 8'h64, 8'h14, 8'h5a, 8'h0a,
		8'h0a, 8'h5a, 8'h50, 8'ha0, 8'h14, 8'h64, 8'h46, 8'h96,
		8'h1e, 8'h6e, 8'h3c, 8'h8c, 8'h28, 8'h78, 8'h32, 8'h82,
		8'h82, 8'h32, 8'h78, 8'h28, 8'h8c, 8'h3c, 8'h6e, 8'h1e,
		8'h96, 8'h46, 8'h64, 8'h14, 8'ha0, 8'h50, 8'h5a, 8'h0a,
		8'h28, 8'h78, 8'h0a, 8'h5a, 8'h50, 8'ha0, 8'h14, 8'h64,
		8'h1e, 8'h6e, 8'h3c, 8'h8c, 8'h32, 8'h82, 8'h46, 8'h96,
		8'h96, 8'h46, 8'h82, 8'h32, 8'h8c, 8'h3c, 8'h6e, 8'h1e,
		8'h64, 8'h14, 8'ha0, 8'h50, 8'h5a, 8'h0a, 8'h78, 8'h28,
		8'h50, 8'ha0, 8'h28, 8'h78, 8'h0a, 8'h5a, 8'h1e, 8'h6e,
		8'h3c, 8'h8c, 8'h32, 8'h82, 8'h46, 8'h96, 8'h14, 8'h64,
		8'h64, 8'h14, 8'h96, 8'h46, 8'h82, 8'h32, 8'h8c, 8'h3c,
		8'h6e, 8'h1e, 8'h5a, 8'h0a, 8'h78, 8'h28, 8'ha0, 8'h50,
		8'h50, 8'ha0, 8'h46, 8'h96, 8'h3c, 8'h8c, 8'h28, 8'h78,
		8'h0a, 8'h5a, 8'h32, 8'h82, 8'h1e, 8'h6e, 8'h14, 8'h64,
		8'h64, 8'h14, 8'h6e, 8'h1e, 8'h82, 8'h32, 8'h5a, 8'h0a,
		8'h78, 8'h28, 8'h8c, 8'h3c, 8'h96, 8'h46, 8'ha0, 8'h50,
		8'h46, 8'h96, 8'h3c, 8'h8c, 8'h50, 8'ha0, 8'h28, 8'h78,
		8'h0a, 8'h5a, 8'h1e, 8'h6e, 8'h32, 8'h82, 8'h14, 8'h64,
		8'h64, 8'h14, 8'h82, 8'h32, 8'h6e, 8'h1e, 8'h5a, 8'h0a,
		8'h78, 8'h28, 8'ha0, 8'h50, 8'h8c, 8'h3c, 8'h96, 8'h46,
		8'h46, 8'h96, 8'h0a, 8'h5a, 8'h3c, 8'h8c, 8'h14, 8'h64,
		8'h50, 8'ha0, 8'h28, 8'h78, 8'h1e, 8'h6e, 8'h32, 8'h82,
		8'h82, 8'h32, 8'h6e, 8'h1e, 8'h78, 8'h28, 8'ha0, 8'h50,
		8'h64, 8'h14, 8'h8c, 8'h3c, 8'h5a, 8'h0a, 8'h96, 8'h46,
		8'h46, 8'h96, 8'h0a, 8'h5a, 8'h50, 8'ha0, 8'h3c, 8'h8c,
		8'h28, 8'h78, 8'h1e, 8'h6e, 8'h32, 8'h82, 8'h14, 8'h64,
		8'h64, 8'h14, 8'h82, 8'h32, 8'h6e, 8'h1e, 8'h78, 8'h28,
		8'h8c, 8'h3c, 8'ha0, 8'h50, 8'h5a, 8'h0a, 8'h96, 8'h46
	};

endpackage

>>> rtl/core/rchop_ctrl.sv
// Sequencer for the hopping link: takes input words and steps through the hop word
// and the frame bytes. Depends on rchop_pkg.
module rchop_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rchop_pkg::dp_status_t status,
	output rchop_pkg::dp_cmd_t    cmd
);
	import rchop_pkg::*;

	ctrl_state_t     state_q, state_d;
	logic            frame_q, frame_d;
	logic [CH_W-1:0] ch_q, ch_d;
	logic            last_ch;

	assign last_ch = (ch_q == CH_W'(NCH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			frame_q <= 1'b0;
			ch_q <= '0;
		end else begin
			state_q <= state_d;
			frame_q <= frame_d;
			ch_q <= ch_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		frame_d = frame_q;
		ch_d = ch_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					frame_d = status.frame_now;
					if (status.hop_now) begin
						state_d = S_HOP;
					end else if (status.frame_now) begin
						state_d = S_HDR0;
					end
				end
			end
			S_HOP: begin
				if (status.out_free) begin
					state_d = frame_q ? S_HDR0 : S_IDLE;
				end
			end
			S_HDR0: begin
				if (status.out_free) begin
					state_d = S_HDR1;
				end
			end
			S_HDR1: begin
				if (status.out_free) begin
					state_d = S_CHHI;
					ch_d = '0;
				end
			end
			S_CHHI: begin
				if (status.out_free && status.ch_ready) begin
					state_d = S_CHLO;
				end
			end
			S_CHLO: begin
				if (status.out_free) begin
					if (last_ch) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_CHHI;
						ch_d = ch_q + CH_W'(1);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		in_stall = (state_q != S_IDLE);
		cmd.accept = in_valid && (state_q == S_IDLE);
		cmd.emit = 1'b0;
		cmd.sel = SEL_HOP;
		cmd.last = 1'b0;
		cmd.ch = ch_q;
		case (state_q)
			S_IDLE: begin
				cmd.emit = 1'b0;
			end
			S_HOP: begin
				cmd.emit = status.out_free;
				cmd.last = !frame_q;
			end
			S_HDR0: begin
				cmd.emit = status.out_free;
				cmd.sel = SEL_SYNC0;
			end
			S_HDR1: begin
				cmd.emit = status.out_free;
				cmd.sel = SEL_SYNC1;
			end
			S_CHHI: begin
				cmd.emit = status.out_free && status.ch_ready;
				cmd.sel = SEL_HI;
			end
			S_CHLO: begin
				cmd.emit = status.out_free;
				cmd.sel = SEL_LO;
				cmd.last = last_ch;
			end
			default: cmd.emit = 1'b0;
		endcase
	end

`ifndef SYNTH
	a_hi_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && state_q == S_CHHI) |-> status.ch_ready)
		else $error("frame byte emitted before its channel value was ready");
	a_ch_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHHI || state_q == S_CHLO) |-> (ch_q < CH_W'(NCH)))
		else $error("channel index beyond frame length");
	a_frame_after_hop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOP && status.out_free && frame_q) |=> (state_q == S_HDR0))
		else $error("frame lost after hop word");
`endif

endmodule

>>> rtl/core/rchop_dp.sv
// Datapath of the hopping link: configuration registers, link state, hop table lookup,
// channel scaling pipeline and output register. Depends on rchop_pkg.
module rchop_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rchop_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	input  logic                             req_type,
	input  logic [31:0]                      packet_id,
	input  logic [15:0]                      raw [rchop_pkg::IN_CHANS],
	input  rchop_pkg::dp_cmd_t               cmd,
	output rchop_pkg::dp_status_t            status,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             kind,
	output logic [7:0]                       value,
	output logic                             last
);
	import rchop_pkg::*;

	// Configuration.
	logic [31:0] tx_id_q;
	logic        wide_q;
	logic [7:0]  period_q;
	logic [7:0]  fpp_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	// Link state.
	logic [HOP_W-1:0] col_q;
	logic [4:0]       sil_q;
	logic [4:0]       lim_q;
	logic [15:0]      lost_q;
	logic [7:0]       timer_q;
	logic [7:0]       fresh_q;
	logic [15:0]      stored_q [IN_CHANS];
	logic [7:0]       hop_chan_q;

	// Scaling pipeline.
	logic            calc_run_q;
	logic [CH_W-1:0] calc_idx_q;
	logic            vld_s1;
	logic [CH_W-1:0] idx_s1;
	logic [26:0]     x_s1;
	logic [15:0]     res_q [NCH];
	logic [NCH-1:0]  res_vld_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  value_q;
	logic        last_q;

	logic        pkt_match;
	logic [4:0]  sil_inc;
	logic        hop_tick;
	logic [15:0] lost_inc;
	logic        frame_tick;
	logic [3:0]  offs;
	logic [7:0]  hop_chan;
	logic [15:0] v_sub;
	logic [10:0] scale;
	logic [26:0] x_calc;
	logic [54:0] prod;
	logic [10:0] q11;
	logic [15:0] word;
	logic [15:0] res_sel;
	logic [7:0]  byte_sel;
	logic        out_free;

	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (cfg_idx)
			REG_TX_ID:  prdata = tx_id_q;
			REG_WIDE:   prdata = {31'd0, wide_q};
			REG_PERIOD: prdata = {24'd0, period_q};
			REG_FPP:    prdata = {24'd0, fpp_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign pkt_match = (packet_id == tx_id_q);
	assign sil_inc = (sil_q < SIL_MAX) ? sil_q + 5'd1 : sil_q;
	assign hop_tick = (sil_inc >= lim_q);
	assign lost_inc = (lost_q == LOST_MAX) ? lost_q : lost_q + 16'd1;
	assign frame_tick = (timer_q >= period_q) && (fresh_q != 8'd0);
	assign offs = (tx_id_q[7:4] > OFFS_MAX) ? OFFS_MAX : tx_id_q[7:4];
	assign hop_chan = HOP_ROM[{tx_id_q[3:0], col_q}] - {4'd0, offs} - 8'd1;

	assign status.hop_now = req_type ? pkt_match : hop_tick;
	assign status.frame_now = !req_type && frame_tick;
	assign status.out_free = out_free;
	assign status.ch_ready = res_vld_q[cmd.ch];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_id_q <= TX_ID_RST;
			wide_q <= WIDE_RST;
			period_q <= PERIOD_RST;
			fpp_q <= FPP_RST;
			col_q <= '0;
			sil_q <= '0;
			lim_q <= LIM_LONG;
			lost_q <= '0;
			timer_q <= '0;
			fresh_q <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_TX_ID:  tx_id_q <= pwdata;
					REG_WIDE:   wide_q <= pwdata[0];
					REG_PERIOD: period_q <= pwdata[7:0];
					REG_FPP:    fpp_q <= pwdata[7:0];
					default:    tx_id_q <= tx_id_q;
				endcase
			end
			if (cmd.accept) begin
				if (req_type) begin
					if (pkt_match) begin
						col_q <= col_q + HOP_W'(1);
						fresh_q <= fpp_q;
						lost_q <= '0;
						sil_q <= '0;
						lim_q <= LIM_LONG;
					end
				end else begin
					if (hop_tick) begin
						col_q <= col_q + HOP_W'(1);
						sil_q <= '0;
						lost_q <= lost_inc;
						lim_q <= (lost_inc < LOST_LIMIT) ? LIM_SHORT : LIM_LONG;
					end else begin
						sil_q <= sil_inc;
					end
					if (frame_tick) begin
						fresh_q <= fresh_q - 8'd1;
						timer_q <= '0;
					end else if (timer_q != TIMER_MAX) begin
						timer_q <= timer_q + 8'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hop_chan_q <= hop_chan;
			if (req_type && pkt_match) begin
				for (int i = 0; i < IN_CHANS; i++) begin
					stored_q[i] <= raw[i];
				end
			end
		end
	end

	// Channel values are scaled one per cycle, starting when a frame is decided,
	// and run ahead of the byte sequencer.
	assign v_sub = (stored_q[calc_idx_q] > RAW_OFFSET) ? stored_q[calc_idx_q] - RAW_OFFSET
		: 16'd0;
	assign scale = wide_q ? SCALE_WIDE : SCALE_NARROW;
	assign x_calc = ({11'd0, v_sub} * {16'd0, scale}) + ROUND_ADD;
	assign prod = {28'd0, x_s1} * {27'd0, RECIP_1000};
	assign q11 = prod[RECIP_SHIFT+10:RECIP_SHIFT];
	assign word = wide_q ? {2'd0, idx_s1, q11} : {3'd0, idx_s1, q11[9:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_run_q <= 1'b0;
			calc_idx_q <= '0;
			vld_s1 <= 1'b0;
			res_vld_q <= '0;
		end else begin
			vld_s1 <= calc_run_q;
			if (cmd.accept && !req_type && frame_tick) begin
				calc_run_q <= 1'b1;
				calc_idx_q <= '0;
				res_vld_q <= '0;
			end else begin
				if (calc_run_q) begin
					if (calc_idx_q == CH_W'(NCH - 1)) begin
						calc_run_q <= 1'b0;
					end else begin
						calc_idx_q <= calc_idx_q + CH_W'(1);
					end
				end
				if (vld_s1) begin
					res_vld_q[idx_s1] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_calc;
		idx_s1 <= calc_idx_q;
		if (vld_s1) begin
			res_q[idx_s1] <= word;
		end
	end

	// Output register.
	assign out_free = !out_valid_q || !out_stall;
	assign res_sel = res_q[cmd.ch];

	always_comb begin
		case (cmd.sel)
			SEL_HOP:   byte_sel = hop_chan_q;
			SEL_SYNC0: byte_sel = FRAME_SYNC0;
			SEL_SYNC1: byte_sel = FRAME_SYNC1;
			SEL_HI:    byte_sel = res_sel[15:8];
			SEL_LO:    byte_sel = res_sel[7:0];
			default:   byte_sel = FRAME_SYNC0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= (cmd.sel == SEL_HOP) ? KIND_CHAN : KIND_BYTE;
			value_q <= byte_sel;
			last_q <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign value = value_q;
	assign last = last_q;

`ifndef SYNTH
	a_silence_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sil_q < LIM_LONG)
		else $error("silence counter passed its limit");
	a_packet_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && req_type && pkt_match) |=> (lost_q == 16'd0 && sil_q == 5'd0))
		else $error("matching packet did not clear the link timers");
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("output register overwritten while stalled");
	a_scale_index: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (idx_s1 < CH_W'(NCH)))
		else $error("scaling pipeline index beyond frame length");
`endif

endmodule

>>> rtl/core/rc_hop_link_and_frame_builder.sv
// Top level of the hopping radio link and serial frame builder.
// Instantiates rchop_ctrl and rchop_dp; depends on rchop_pkg.

// Each input word is a 100 us tick or a received packet. The block takes a word when
// it is idle, then holds in_stall high while it delivers that word's results, one per
// cycle unless out_stall holds them back: a matching packet gives one hop word, a tick
// gives nothing, a hop word, a 16-byte frame, or both. The channel scaling pipeline
// (two multiplier stages) starts when a tick decides a frame and stays ahead of the
// byte sequencer in rchop_ctrl. A packet whose id does not match is taken and changes
// nothing. The user must write configuration over the APB port only while the block is
// idle; the block itself does not enforce this. The registers are tx_id at 0x0,
// wide_resolution at 0x4, frame_period_ticks at 0x8 and frames_per_packet at 0xC.
module rc_hop_link_and_frame_builder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rchop_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [31:0]                  packet_id,
	input  logic [15:0]                  chan0_raw,
	input  logic [15:0]                  chan1_raw,
	input  logic [15:0]                  chan2_raw,
	input  logic [15:0]                  chan3_raw,
	input  logic [15:0]                  chan4_raw,
	input  logic [15:0]                  chan5_raw,
	input  logic [15:0]                  chan6_raw,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         kind,
	output logic [7:0]                   value,
	output logic                         last
);
	import rchop_pkg::*;

	logic [15:0] raw [IN_CHANS];
	dp_cmd_t     cmd;
	dp_status_t  status;

	assign pready = 1'b1;

	assign raw[0] = chan0_raw;
	assign raw[1] = chan1_raw;
	assign raw[2] = chan2_raw;
	assign raw[3] = chan3_raw;
	assign raw[4] = chan4_raw;
	assign raw[5] = chan5_raw;
	assign raw[6] = chan6_raw;

	rchop_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rchop_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.req_type  (req_type),
		.packet_id (packet_id),
		.raw       (raw),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

endmodule
